// ===== src/sht_pkg.sv =====
// shared types and constants of the shape table hit test
package sht_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [2:0] KIND_NONE      = 3'd0;
  localparam logic [2:0] KIND_CIRCLE    = 3'd1;
  localparam logic [2:0] KIND_ELLIPSE   = 3'd2;
  localparam logic [2:0] KIND_TRIANGLE  = 3'd3;
  localparam logic [2:0] KIND_SQUARE    = 3'd4;
  localparam logic [2:0] KIND_RECTANGLE = 3'd5;
  localparam logic [2:0] KIND_RHOMBUS   = 3'd6;

  // one table row: flag, kind and six Q16.16 parameters
  typedef struct packed {
    logic             vis;
    logic [2:0]       kind;
    logic [5:0][31:0] p;
  } row_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } hit_req_t;

  typedef struct packed {
    logic done;
    logic contained;
  } hit_rsp_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_READ,
    T_START,
    T_WAIT,
    T_NEXT,
    T_FINISH
  } scan_state_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_RUN,
    U_EVAL
  } unit_state_t;

endpackage

// ===== src/sht_ifs.sv =====
// valid/ready channel interfaces for shape words and hit words
interface sht_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [3:0]         slot;
  logic [2:0]         shape_kind;
  logic               on_scene;
  logic signed [31:0] value_0;
  logic signed [31:0] value_1;
  logic signed [31:0] value_2;
  logic signed [31:0] value_3;
  logic signed [31:0] value_4;
  logic signed [31:0] value_5;

  modport source (output valid, operation, slot, shape_kind, on_scene,
                  value_0, value_1, value_2, value_3, value_4, value_5,
                  input ready);
  modport sink (input valid, operation, slot, shape_kind, on_scene,
                value_0, value_1, value_2, value_3, value_4, value_5,
                output ready);
endinterface

interface sht_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] hit_slot;
  logic       hit;
  logic       last;

  modport source (output valid, hit_slot, hit, last, input ready);
  modport sink (input valid, hit_slot, hit, last, output ready);
endinterface

// ===== src/shape_table_point_hit_test.sv =====
// shape table with point hit test: slot scan, valid bits and result register
//
//  channel  dir  words                                             accepted when
//  cmd      in   operation slot shape_kind on_scene value_0..5     valid && ready
//  res      out  hit_slot hit last                                 valid && ready
//
// a write is accepted in T_IDLE; a query visits T_READ, T_START and T_NEXT per slot and
// adds T_WAIT only when the slot is written and shown (n multiplier steps: 0 box,
// 3 circle or rhombus, 6 triangle, 12 ellipse, all on the single 34x34 multiplier)
// reset clears the slot valid bits at once; rows of unwritten slots read as empty
// a stalled result word holds the scan until the output register frees up
module shape_table_point_hit_test
  import sht_pkg::*;
#(
  parameter int MAX_SHAPES = 16
) (
  input logic        clk,
  input logic        rst,
  sht_in_if.sink     cmd,
  sht_out_if.source  res
);

  localparam int AW         = MAX_SHAPES > 1 ? $clog2(MAX_SHAPES) : 1;
  localparam int SCAN_LIMIT = MAX_SHAPES < 16 ? MAX_SHAPES : 16;

  scan_state_t state, state_next;

  logic [MAX_SHAPES-1:0] slot_valid;
  logic [3:0]            scan;
  logic                  cur_hit;
  logic                  pend_valid;
  logic [3:0]            pend_slot;
  logic signed [31:0]    qx, qy;

  logic     out_free;
  logic     push;
  logic [3:0] push_slot;
  logic     push_hit;
  logic     push_last;
  logic     wr_en;
  logic     rd_en;
  logic     in_range;
  row_t     wr_row;
  row_t     rd_row;
  hit_req_t req;
  hit_rsp_t rsp;
  logic     scan_last;
  logic     slot_live;

  assign in_range  = 32'(cmd.slot) < MAX_SHAPES;
  assign wr_en     = cmd.valid && cmd.ready && cmd.operation == OP_WRITE && in_range;
  assign wr_row    = '{vis: cmd.on_scene, kind: cmd.shape_kind,
                       p: {cmd.value_5, cmd.value_4, cmd.value_3,
                           cmd.value_2, cmd.value_1, cmd.value_0}};
  assign scan_last = scan == 4'(SCAN_LIMIT - 1);
  assign slot_live = slot_valid[AW'(scan)] && rd_row.vis;
  assign out_free  = !res.valid || res.ready;

  sht_param_mem #(.DEPTH(MAX_SHAPES)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(cmd.slot)),
    .wr_data (wr_row),
    .rd_en   (rd_en),
    .rd_addr (AW'(scan)),
    .rd_data (rd_row)
  );

  sht_hit_unit u_hit (
    .clk (clk),
    .rst (rst),
    .req (req),
    .row (rd_row),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.ready  = 1'b0;
    rd_en      = 1'b0;
    req.start  = 1'b0;
    req.x      = qx;
    req.y      = qy;
    push       = 1'b0;
    push_slot  = pend_slot;
    push_hit   = 1'b1;
    push_last  = 1'b0;
    case (state)
      T_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid && cmd.operation == OP_QUERY) begin
          state_next = T_READ;
        end
      end
      T_READ: begin
        rd_en      = 1'b1;
        state_next = T_START;
      end
      T_START: begin
        if (slot_live) begin
          req.start  = 1'b1;
          state_next = T_WAIT;
        end else begin
          state_next = T_NEXT;
        end
      end
      T_WAIT: begin
        if (rsp.done) begin
          state_next = T_NEXT;
        end
      end
      T_NEXT: begin
        // an earlier hit goes out once a later one shows it is not the last
        if (!(cur_hit && pend_valid && !out_free)) begin
          push       = cur_hit && pend_valid;
          state_next = scan_last ? T_FINISH : T_READ;
        end
      end
      T_FINISH: begin
        if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          push_hit   = pend_valid;
          push_slot  = pend_valid ? pend_slot : 4'd0;
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      res.valid  <= 1'b0;
      pend_valid <= 1'b0;
      cur_hit    <= 1'b0;
      scan       <= 4'd0;
    end else begin
      if (wr_en) begin
        slot_valid[AW'(cmd.slot)] <= 1'b1;
      end
      if (push) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (cmd.valid && cmd.operation == OP_QUERY) begin
            scan       <= 4'd0;
            pend_valid <= 1'b0;
          end
        end
        T_START: begin
          cur_hit <= 1'b0;
        end
        T_WAIT: begin
          if (rsp.done) begin
            cur_hit <= rsp.contained;
          end
        end
        T_NEXT: begin
          if (state_next != T_NEXT) begin
            if (cur_hit) begin
              pend_valid <= 1'b1;
            end
            if (!scan_last) begin
              scan <= scan + 4'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == T_IDLE && cmd.valid && cmd.operation == OP_QUERY) begin
      qx <= cmd.value_0;
      qy <= cmd.value_1;
    end
    if (state == T_NEXT && state_next != T_NEXT && cur_hit) begin
      pend_slot <= scan;
    end
    if (push) begin
      res.hit_slot <= push_slot;
      res.hit      <= push_hit;
      res.last     <= push_last;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> state == T_WAIT)
    else $error("hit unit finished outside the wait state");

  a_last_ends_query: assert property (@(posedge clk) disable iff (rst)
    push && push_last |=> state == T_IDLE)
    else $error("final word pushed but scan did not return to idle");

  a_nohit_is_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.hit |-> res.last)
    else $error("no-hit word without last");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state != T_IDLE |-> 32'(scan) < SCAN_LIMIT)
    else $error("scan index beyond table");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("result pushed into a full output register");

endmodule

// ===== src/sht_param_mem.sv =====
// shape row memory, one row per slot, registered read
module sht_param_mem
  import sht_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  row_t                                     wr_data,
  input  logic                                     rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output row_t                                     rd_data
);

  row_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/sht_hit_unit.sv =====
// containment test of one shape, stepped through one shared multiplier
module sht_hit_unit
  import sht_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  hit_req_t req,
  input  row_t     row,
  output hit_rsp_t rsp
);

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_1  = 2'd1;
  localparam logic [1:0] SH_33 = 2'd2;
  localparam logic [1:0] SH_64 = 2'd3;

  localparam logic [2:0] DST_ACC0 = 3'd0;
  localparam logic [2:0] DST_ACC1 = 3'd1;
  localparam logic [2:0] DST_ACC2 = 3'd2;
  localparam logic [2:0] DST_M0   = 3'd3;
  localparam logic [2:0] DST_M1   = 3'd4;
  localparam logic [2:0] DST_M2   = 3'd5;

  unit_state_t ustate, ustate_next;
  logic [3:0]  step;
  logic [3:0]  n_steps;

  logic signed [129:0] acc0, acc1, acc2;
  logic [62:0]         m0, m1, m2;

  logic signed [33:0] xw, yw, pw0, pw1, pw2, pw3, pw4, pw5;
  logic signed [33:0] dx, dy, adx, ady;
  logic signed [33:0] ta, tb, tc, te, tf, qx, qy;
  logic signed [33:0] opa, opb;
  logic [1:0]         sh;
  logic [2:0]         dst;
  logic signed [67:0] prod;
  logic signed [67:0] prod_mag;
  logic signed [129:0] ext, addend;

  logic signed [69:0] d70, na70, nb70, dn, nan, nbn, nc;
  logic               contained;

  assign xw  = 34'(req.x);
  assign yw  = 34'(req.y);
  assign pw0 = 34'($signed(row.p[0]));
  assign pw1 = 34'($signed(row.p[1]));
  assign pw2 = 34'($signed(row.p[2]));
  assign pw3 = 34'($signed(row.p[3]));
  assign pw4 = 34'($signed(row.p[4]));
  assign pw5 = 34'($signed(row.p[5]));

  assign dx  = xw - pw0;
  assign dy  = yw - pw1;
  assign adx = dx[33] ? -dx : dx;
  assign ady = dy[33] ? -dy : dy;
  assign ta  = pw3 - pw5;
  assign tb  = pw4 - pw2;
  assign tc  = pw5 - pw1;
  assign te  = pw0 - pw4;
  assign tf  = pw1 - pw5;
  assign qx  = xw - pw4;
  assign qy  = yw - pw5;

  // step schedule per kind: operands, shift and destination
  always_comb begin
    opa     = '0;
    opb     = '0;
    sh      = SH_0;
    dst     = DST_ACC0;
    n_steps = 4'd0;
    case (row.kind)
      KIND_CIRCLE: begin
        n_steps = 4'd3;
        case (step)
          4'd0: begin opa = dx; opb = dx; end
          4'd1: begin opa = dy; opb = dy; end
          4'd2: begin opa = pw2; opb = pw2; dst = DST_ACC1; end
          default: ;
        endcase
      end
      KIND_ELLIPSE: begin
        // squares of the 63 bit magnitudes split into high and low halves
        n_steps = 4'd12;
        case (step)
          4'd0:  begin opa = dx; opb = pw3; dst = DST_M0; end
          4'd1:  begin opa = dy; opb = pw2; dst = DST_M1; end
          4'd2:  begin opa = pw2; opb = pw3; dst = DST_M2; end
          4'd3:  begin opa = {3'b0, m0[62:32]}; opb = {3'b0, m0[62:32]}; sh = SH_64; end
          4'd4:  begin opa = {3'b0, m0[62:32]}; opb = {2'b0, m0[31:0]}; sh = SH_33; end
          4'd5:  begin opa = {2'b0, m0[31:0]}; opb = {2'b0, m0[31:0]}; end
          4'd6:  begin opa = {3'b0, m1[62:32]}; opb = {3'b0, m1[62:32]}; sh = SH_64; end
          4'd7:  begin opa = {3'b0, m1[62:32]}; opb = {2'b0, m1[31:0]}; sh = SH_33; end
          4'd8:  begin opa = {2'b0, m1[31:0]}; opb = {2'b0, m1[31:0]}; end
          4'd9:  begin
            opa = {3'b0, m2[62:32]}; opb = {3'b0, m2[62:32]}; sh = SH_64; dst = DST_ACC1;
          end
          4'd10: begin
            opa = {3'b0, m2[62:32]}; opb = {2'b0, m2[31:0]}; sh = SH_33; dst = DST_ACC1;
          end
          4'd11: begin
            opa = {2'b0, m2[31:0]}; opb = {2'b0, m2[31:0]}; dst = DST_ACC1;
          end
          default: ;
        endcase
      end
      KIND_TRIANGLE: begin
        n_steps = 4'd6;
        case (step)
          4'd0: begin opa = ta; opb = te; dst = DST_ACC2; end
          4'd1: begin opa = tb; opb = tf; dst = DST_ACC2; end
          4'd2: begin opa = ta; opb = qx; end
          4'd3: begin opa = tb; opb = qy; end
          4'd4: begin opa = tc; opb = qx; dst = DST_ACC1; end
          4'd5: begin opa = te; opb = qy; dst = DST_ACC1; end
          default: ;
        endcase
      end
      KIND_RHOMBUS: begin
        n_steps = 4'd3;
        case (step)
          4'd0: begin opa = adx; opb = pw3; sh = SH_1; end
          4'd1: begin opa = ady; opb = pw2; sh = SH_1; end
          4'd2: begin opa = pw2; opb = pw3; dst = DST_ACC1; end
          default: ;
        endcase
      end
      default: n_steps = 4'd0;
    endcase
  end

  assign prod     = opa * opb;
  assign prod_mag = prod[67] ? -prod : prod;
  assign ext      = 130'(prod);

  always_comb begin
    case (sh)
      SH_1:    addend = ext <<< 1;
      SH_33:   addend = ext <<< 33;
      SH_64:   addend = ext <<< 64;
      default: addend = ext;
    endcase
  end

  // final decision from the accumulated terms
  assign d70  = acc2[69:0];
  assign na70 = acc0[69:0];
  assign nb70 = acc1[69:0];
  assign dn   = d70[69] ? -d70 : d70;
  assign nan  = d70[69] ? -na70 : na70;
  assign nbn  = d70[69] ? -nb70 : nb70;
  assign nc   = dn - nan - nbn;

  always_comb begin
    case (row.kind)
      KIND_CIRCLE:    contained = acc0 <= acc1;
      KIND_ELLIPSE:   contained = (pw2 != '0) && (pw3 != '0) && (acc0 <= acc1);
      KIND_TRIANGLE:  contained = (d70 != '0) && !nan[69] && (nan <= dn) && !nbn[69]
                                  && (nbn <= dn) && !nc[69] && (nc <= dn);
      KIND_SQUARE:    contained = (xw >= pw0) && (xw <= pw0 + pw2)
                                  && (yw >= pw1) && (yw <= pw1 + pw2);
      KIND_RECTANGLE: contained = (xw >= pw0) && (xw <= pw0 + pw2)
                                  && (yw >= pw1) && (yw <= pw1 + pw3);
      KIND_RHOMBUS:   contained = (pw2 > 0) && (pw3 > 0) && (acc0 <= acc1);
      default:        contained = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ustate <= U_IDLE;
    end else begin
      ustate <= ustate_next;
    end
  end

  always_comb begin
    ustate_next   = ustate;
    rsp.done      = 1'b0;
    rsp.contained = 1'b0;
    case (ustate)
      U_IDLE: begin
        if (req.start) begin
          ustate_next = (n_steps == 4'd0) ? U_EVAL : U_RUN;
        end
      end
      U_RUN: begin
        if (step == n_steps - 4'd1) begin
          ustate_next = U_EVAL;
        end
      end
      U_EVAL: begin
        rsp.done      = 1'b1;
        rsp.contained = contained;
        ustate_next   = U_IDLE;
      end
      default: ustate_next = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ustate == U_IDLE && req.start) begin
      step <= 4'd0;
      acc0 <= '0;
      acc1 <= '0;
      acc2 <= '0;
    end else if (ustate == U_RUN) begin
      step <= step + 4'd1;
      case (dst)
        DST_ACC0: acc0 <= acc0 + addend;
        DST_ACC1: acc1 <= acc1 + addend;
        DST_ACC2: acc2 <= acc2 + addend;
        DST_M0:   m0 <= prod_mag[62:0];
        DST_M1:   m1 <= prod_mag[62:0];
        DST_M2:   m2 <= prod_mag[62:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== tb/tb_shape_table_point_hit_test.sv =====
// testbench for the shape table point hit test, checked against a predictor
module tb_shape_table_point_hit_test
  import sht_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic              operation;
    logic [3:0]        slot;
    logic [2:0]        shape_kind;
    logic              on_scene;
    logic signed [31:0] v [6];
    bit                drain_first;
  } shape_word_t;

  typedef struct {
    logic [3:0] hit_slot;
    logic       hit;
    logic       last;
  } hit_word_t;

  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD = 500;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sht_in_if  cmd_if ();
  sht_out_if res_if ();

  shape_table_point_hit_test u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  always #5 clk = ~clk;

  shape_word_t pending_words[$];
  hit_word_t   expected_hits[$];
  shape_word_t cur_word;
  int          errors = 0;
  int          words_sent = 0;
  int          hits_seen = 0;
  int          send_gap = 0;
  int          recv_hold = 0;
  bit          long_hold_done = 1'b0;
  int          idle_cycles = 0;

  // predictor copy of the shape table
  logic [2:0] kind_tbl [16];
  logic       shown_tbl [16];
  longint     param_tbl [16][6];

  function automatic wide_t wmul(longint a, longint b);
    return wide_t'(a) * wide_t'(b);
  endfunction

  function automatic bit point_inside(int s, longint x, longint y);
    longint p [6];
    longint dx, dy, u, v, ab, adx, ady;
    wide_t  d, na, nb, nc;
    for (int k = 0; k < 6; k++) p[k] = param_tbl[s][k];
    dx = x - p[0];
    dy = y - p[1];
    case (kind_tbl[s])
      KIND_CIRCLE: return wmul(dx, dx) + wmul(dy, dy) <= wmul(p[2], p[2]);
      KIND_ELLIPSE: begin
        if (p[2] == 0 || p[3] == 0) return 1'b0;
        // these products fit in 64 bits
        u = dx * p[3];
        v = dy * p[2];
        ab = p[2] * p[3];
        return wmul(u, u) + wmul(v, v) <= wmul(ab, ab);
      end
      KIND_TRIANGLE: begin
        d = wmul(p[3] - p[5], p[0] - p[4]) + wmul(p[4] - p[2], p[1] - p[5]);
        if (d == 0) return 1'b0;
        na = wmul(p[3] - p[5], x - p[4]) + wmul(p[4] - p[2], y - p[5]);
        nb = wmul(p[5] - p[1], x - p[4]) + wmul(p[0] - p[4], y - p[5]);
        if (d < 0) begin
          d = -d;
          na = -na;
          nb = -nb;
        end
        nc = d - na - nb;
        return na >= 0 && na <= d && nb >= 0 && nb <= d && nc >= 0 && nc <= d;
      end
      KIND_SQUARE: return x >= p[0] && x <= p[0] + p[2] && y >= p[1] && y <= p[1] + p[2];
      KIND_RECTANGLE: return x >= p[0] && x <= p[0] + p[2] && y >= p[1] && y <= p[1] + p[3];
      KIND_RHOMBUS: begin
        if (p[2] <= 0 || p[3] <= 0) return 1'b0;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        return 2 * wmul(adx, p[3]) + 2 * wmul(ady, p[2]) <= wmul(p[2], p[3]);
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic apply_word(shape_word_t w);
    hit_word_t h;
    int n;
    if (w.operation == OP_WRITE) begin
      kind_tbl[w.slot] = w.shape_kind;
      shown_tbl[w.slot] = w.on_scene;
      for (int k = 0; k < 6; k++) param_tbl[w.slot][k] = longint'(w.v[k]);
    end else begin
      n = 0;
      for (int s = 0; s < 16; s++) begin
        if (shown_tbl[s] && point_inside(s, longint'(w.v[0]), longint'(w.v[1]))) begin
          h.hit_slot = s[3:0];
          h.hit = 1'b1;
          h.last = 1'b0;
          expected_hits.insert(expected_hits.size(), h);
          n++;
        end
      end
      if (n == 0) begin
        h.hit_slot = 4'd0;
        h.hit = 1'b0;
        h.last = 1'b1;
        expected_hits.insert(expected_hits.size(), h);
      end else begin
        expected_hits[$].last = 1'b1;
      end
    end
  endtask

  function automatic int q16(int n);
    return n <<< 16;
  endfunction

  task automatic add_write(int s, logic [2:0] k, logic vis, int a, int b, int c,
                           int d, int e, int f);
    shape_word_t w;
    w.operation = OP_WRITE;
    w.slot = s[3:0];
    w.shape_kind = k;
    w.on_scene = vis;
    w.v = '{a, b, c, d, e, f};
    w.drain_first = 1'b0;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic add_query(int x, int y, bit drain);
    shape_word_t w;
    w.operation = OP_QUERY;
    w.slot = 4'($urandom());
    w.shape_kind = 3'($urandom());
    w.on_scene = 1'($urandom());
    w.v = '{x, y, $urandom(), $urandom(), $urandom(), $urandom()};
    w.drain_first = drain;
    pending_words.insert(pending_words.size(), w);
  endtask

  // small coordinates make hits common; now and then a full-range value
  function automatic int rand_coord();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return q16($urandom_range(0, 40) - 20) + $urandom_range(0, 65535);
  endfunction

  function automatic int rand_size();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return -q16($urandom_range(1, 5));
      2: return $urandom();
      default: return q16($urandom_range(1, 20)) + $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int rand_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 0;
      6, 7, 8: return $urandom_range(1, 3);
      default: return $urandom_range(10, 40);
    endcase
  endfunction

  task automatic build_stimulus();
    add_query(0, 0, 1'b0);
    add_write(0, KIND_CIRCLE, 1'b1, 0, 0, q16(5), 0, 0, 0);
    add_write(1, KIND_ELLIPSE, 1'b1, 0, 0, q16(6), q16(3), 0, 0);
    add_write(2, KIND_TRIANGLE, 1'b1, q16(-4), q16(-4), q16(8), q16(-4), q16(-4), q16(8));
    add_write(3, KIND_SQUARE, 1'b1, q16(-2), q16(-2), q16(4), 0, 0, 0);
    add_write(4, KIND_RECTANGLE, 1'b1, q16(-3), q16(-1), q16(6), q16(2), 0, 0);
    add_write(5, KIND_RHOMBUS, 1'b1, 0, 0, q16(6), q16(4), 0, 0);
    add_write(6, 3'd7, 1'b1, 0, 0, q16(9), q16(9), 0, 0);
    add_write(7, KIND_ELLIPSE, 1'b1, 0, 0, 0, q16(3), 0, 0);
    add_write(8, KIND_RHOMBUS, 1'b1, 0, 0, q16(-2), q16(4), 0, 0);
    add_write(9, KIND_TRIANGLE, 1'b1, 0, 0, q16(1), q16(1), q16(2), q16(2));
    add_write(10, KIND_SQUARE, 1'b1, 0, 0, -q16(1), 0, 0, 0);
    add_write(11, KIND_CIRCLE, 1'b0, 0, 0, q16(9), 0, 0, 0);
    add_write(12, KIND_NONE, 1'b1, 0, 0, q16(9), q16(9), 0, 0);
    add_write(15, KIND_CIRCLE, 1'b1, 0, 0, -q16(3), 32'h7fffffff, 32'h7fffffff,
              32'h80000000);
    add_write(14, KIND_RECTANGLE, 1'b1, 32'h80000000, 32'h80000000, 32'h7fffffff,
              32'h7fffffff, 32'h80000000, 32'h7fffffff);
    add_query(0, 0, 1'b0);
    add_query(q16(2), q16(2), 1'b0);
    add_query(q16(1), q16(1), 1'b0);
    add_query(32'h7fffffff, 32'h80000000, 1'b0);
    add_query(32'h80000000, 32'h7fffffff, 1'b0);
    add_query(q16(30), q16(30), 1'b0);
    for (int i = 0; i < 400; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        add_write($urandom_range(0, 15), 3'($urandom_range(0, 7)),
                  $urandom_range(0, 4) != 0,
                  rand_coord(), rand_coord(),
                  rand_size(), rand_size(), rand_coord(), rand_coord());
        // triangles take plain coordinates for all three corners
        if (pending_words[$].shape_kind == KIND_TRIANGLE) begin
          pending_words[$].v[2] = rand_coord();
          pending_words[$].v[3] = rand_coord();
        end
      end else begin
        add_query(rand_coord(), rand_coord(), i == 250);
      end
    end
  endtask

  // sender: one word at a time from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      cmd_if.valid <= 1'b0;
      cmd_if.operation <= OP_WRITE;
      cmd_if.slot <= '0;
      cmd_if.shape_kind <= KIND_NONE;
      cmd_if.on_scene <= 1'b0;
      cmd_if.value_0 <= '0;
      cmd_if.value_1 <= '0;
      cmd_if.value_2 <= '0;
      cmd_if.value_3 <= '0;
      cmd_if.value_4 <= '0;
      cmd_if.value_5 <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        apply_word(cur_word);
        words_sent++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          cmd_if.valid <= 1'b0;
        end else if (pending_words.size() > 0 &&
                     (!pending_words[0].drain_first || expected_hits.size() == 0)) begin
          cur_word = pending_words.pop_front();
          cmd_if.valid <= 1'b1;
          cmd_if.operation <= cur_word.operation;
          cmd_if.slot <= cur_word.slot;
          cmd_if.shape_kind <= cur_word.shape_kind;
          cmd_if.on_scene <= cur_word.on_scene;
          cmd_if.value_0 <= cur_word.v[0];
          cmd_if.value_1 <= cur_word.v[1];
          cmd_if.value_2 <= cur_word.v[2];
          cmd_if.value_3 <= cur_word.v[3];
          cmd_if.value_4 <= cur_word.v[4];
          cmd_if.value_5 <= cur_word.v[5];
          // a stretch with no idle cycles
          send_gap = (words_sent > 180 && words_sent < 240) ? 0 : rand_gap();
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each hit word, stalls at random and holds once for a long stall
  always @(posedge clk) begin
    hit_word_t e;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        hits_seen++;
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected hit word slot=%0d hit=%0b last=%0b", $time,
                   res_if.hit_slot, res_if.hit, res_if.last);
          errors++;
        end else begin
          e = expected_hits.pop_front();
          if (res_if.hit_slot !== e.hit_slot) begin
            $display("%0t: hit_slot expected %0d actual %0d", $time, e.hit_slot,
                     res_if.hit_slot);
            errors++;
          end
          if (res_if.hit !== e.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, e.hit, res_if.hit);
            errors++;
          end
          if (res_if.last !== e.last) begin
            $display("%0t: last expected %0b actual %0b", $time, e.last, res_if.last);
            errors++;
          end
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        res_if.ready <= 1'b0;
      end else if (!long_hold_done && hits_seen >= 40) begin
        long_hold_done = 1'b1;
        recv_hold = LONG_HOLD;
        res_if.ready <= 1'b0;
      end else if (words_sent > 180 && words_sent < 240) begin
        res_if.ready <= 1'b1;
      end else begin
        recv_hold = rand_gap();
        res_if.ready <= (recv_hold == 0);
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int s = 0; s < 16; s++) begin
      kind_tbl[s] = KIND_NONE;
      shown_tbl[s] = 1'b0;
      for (int k = 0; k < 6; k++) param_tbl[s][k] = 0;
    end
    build_stimulus();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (pending_words.size() > 0 || cmd_if.valid);
    do @(posedge clk); while (expected_hits.size() > 0);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sht_pkg.sv
src/sht_ifs.sv
src/sht_param_mem.sv
src/sht_hit_unit.sv
src/shape_table_point_hit_test.sv
tb/tb_shape_table_point_hit_test.sv
